/* hw/rtl/fvm_pkg.sv */
`default_nettype none
package fvm_pkg;

	localparam int FRAC  = 24;
	localparam int STEPS = 24;
	localparam int VAL_W = 32;
	localparam int Z_W   = 34;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [31:0] turn_t;
	typedef logic signed [25:0] coef_t;

	localparam coef_t INV_GAIN   = 26'sd10188014;
	localparam coef_t SQRT3_Q    = 26'sd29058991;
	localparam coef_t SQRT3_HALF = 26'sd14529495;
	localparam val_t  ONE_Q      = 32'sd16777216;
	localparam val_t  HALF_Q     = 32'sd8388608;
	localparam turn_t TURN_QUARTER = 32'h4000_0000;
	localparam turn_t TURN_HALF    = 32'h8000_0000;

	// Reciprocal of 100 for the compare scaling: exact for products below 2^23.
	localparam logic [23:0] DIV100_K  = 24'd10737419;
	localparam int          DIV100_SH = 30;

	typedef struct packed {
		val_t  x;
		val_t  y;
		turn_t z;
	} vec_lane_t;

	typedef struct packed {
		logic  mode;
		val_t  vq;
		val_t  vd;
		turn_t ph;
	} vec_pass_t;

	typedef struct packed {
		val_t                  x;
		val_t                  y;
		logic signed [Z_W-1:0] z;
	} rot_lane_t;

	typedef struct packed {
		logic       mode;
		logic [2:0] sector;
	} rot_pass_t;

	function automatic turn_t atan_turn(input int idx);
		turn_t a;
		unique case (idx)
			0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
			3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
			6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
			9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
			12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
			15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
			18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
			21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

	// Fixed-point product with 24 fraction bits, floor rounded.
	function automatic val_t mul_q(input val_t v, input coef_t c);
		logic signed [VAL_W+25:0] p;
		p = v * c;
		return p[FRAC+VAL_W-1:FRAC];
	endfunction

	function automatic vec_lane_t vec_step(input vec_lane_t a, input int idx);
		val_t      x;
		val_t      y;
		val_t      dx;
		val_t      dy;
		vec_lane_t r;
		x  = a.x;
		y  = a.y;
		dx = y >>> idx;
		dy = x >>> idx;
		if (!y[VAL_W-1]) begin
			r.x = x + dx;
			r.y = y - dy;
			r.z = a.z + atan_turn(idx);
		end else begin
			r.x = x - dx;
			r.y = y + dy;
			r.z = a.z - atan_turn(idx);
		end
		return r;
	endfunction

	function automatic rot_lane_t rot_step(input rot_lane_t a, input int idx);
		val_t                  x;
		val_t                  y;
		val_t                  dx;
		val_t                  dy;
		logic signed [Z_W-1:0] at;
		rot_lane_t             r;
		x  = a.x;
		y  = a.y;
		dx = y >>> idx;
		dy = x >>> idx;
		at = $signed({{(Z_W-32){1'b0}}, atan_turn(idx)});
		if (!a.z[Z_W-1]) begin
			r.x = x - dx;
			r.y = y + dy;
			r.z = a.z - at;
		end else begin
			r.x = x + dx;
			r.y = y - dy;
			r.z = a.z + at;
		end
		return r;
	endfunction

	// Folds the angle into [-90, 90) degrees by flipping the vector.
	function automatic rot_lane_t rot_init(input val_t x, input val_t y, input turn_t ph);
		turn_t     t;
		turn_t     p;
		rot_lane_t r;
		t = ph + TURN_QUARTER;
		p = ph;
		r.x = x;
		r.y = y;
		if (t[31]) begin
			r.x = -x;
			r.y = -y;
			p = ph + TURN_HALF;
		end
		r.z = $signed({{(Z_W-32){p[31]}}, p});
		return r;
	endfunction

	// ceil(s * 2^32 / 6): start of sector s.
	function automatic turn_t sector_lo(input logic [2:0] s);
		turn_t v;
		unique case (s)
			3'd0: v = 32'd0;
			3'd1: v = 32'd715827883;
			3'd2: v = 32'd1431655766;
			3'd3: v = 32'd2147483648;
			3'd4: v = 32'd2863311531;
			3'd5: v = 32'd3579139414;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// floor((s + 1) * 2^32 / 6): end of sector s.
	function automatic logic [33:0] sector_hi(input logic [2:0] s);
		logic [33:0] v;
		unique case (s)
			3'd0: v = 34'd715827882;
			3'd1: v = 34'd1431655765;
			3'd2: v = 34'd2147483648;
			3'd3: v = 34'd2863311530;
			3'd4: v = 34'd3579139413;
			3'd5: v = 34'd4294967296;
			default: v = 34'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fvm_vec_cell.sv */
`default_nettype none
module fvm_vec_cell #(
	parameter int STEP = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  fvm_pkg::vec_lane_t  in_lane,
	input  fvm_pkg::vec_pass_t  in_pass,
	output logic                out_valid,
	output fvm_pkg::vec_lane_t  out_lane,
	output fvm_pkg::vec_pass_t  out_pass
);

	logic               valid_q;
	fvm_pkg::vec_lane_t lane_q;
	fvm_pkg::vec_pass_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lane_q <= fvm_pkg::vec_step(in_lane, STEP);
		pass_q <= in_pass;
	end

	assign out_valid = valid_q;
	assign out_lane  = lane_q;
	assign out_pass  = pass_q;

endmodule
`default_nettype wire

/* hw/rtl/fvm_rot_cell.sv */
`default_nettype none
module fvm_rot_cell #(
	parameter int STEP = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  fvm_pkg::rot_lane_t  in_a,
	input  fvm_pkg::rot_lane_t  in_b,
	input  fvm_pkg::rot_pass_t  in_pass,
	output logic                out_valid,
	output fvm_pkg::rot_lane_t  out_a,
	output fvm_pkg::rot_lane_t  out_b,
	output fvm_pkg::rot_pass_t  out_pass
);

	logic               valid_q;
	fvm_pkg::rot_lane_t a_q;
	fvm_pkg::rot_lane_t b_q;
	fvm_pkg::rot_pass_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= fvm_pkg::rot_step(in_a, STEP);
		b_q    <= fvm_pkg::rot_step(in_b, STEP);
		pass_q <= in_pass;
	end

	assign out_valid = valid_q;
	assign out_a     = a_q;
	assign out_b     = b_q;
	assign out_pass  = pass_q;

endmodule
`default_nettype wire

/* hw/rtl/fvm_duty.sv */
`default_nettype none
module fvm_duty (
	input  wire                clk,
	input  fvm_pkg::val_t      duty,
	input  wire  [15:0]        period,
	output logic [15:0]        compare
);

	logic [6:0]  pct_s1;
	logic [22:0] prod_s2;
	logic [15:0] cmp_s3;

	logic signed [39:0] d_ext;
	logic signed [39:0] d100;
	logic signed [39:0] pct_full;
	logic [46:0]        q_full;
	logic [16:0]        quot;

	always_comb begin
		d_ext    = 40'(duty);
		d100     = d_ext * 40'sd100;
		pct_full = d100 >>> fvm_pkg::FRAC;
		q_full   = 47'(prod_s2) * 47'(fvm_pkg::DIV100_K);
		quot     = q_full[fvm_pkg::DIV100_SH+16:fvm_pkg::DIV100_SH];
	end

	always_ff @(posedge clk) begin
		priority if (pct_full[39]) begin
			pct_s1 <= 7'd0;
		end else if (pct_full > 40'sd100) begin
			pct_s1 <= 7'd100;
		end else begin
			pct_s1 <= pct_full[6:0];
		end
		prod_s2 <= {7'd0, period} * {16'd0, pct_s1};
		cmp_s3  <= (quot == 17'd0) ? 16'd0 : 16'(quot - 17'd1);
	end

	assign compare = cmp_s3;

endmodule
`default_nettype wire

/* hw/rtl/foc_voltage_modulator_unit.sv */
`default_nettype none
// Voltage modulator for field-oriented control: each transaction takes Uq, Ud and the
// electrical angle and returns three PWM compare values and a sector number. A new
// transaction is taken in every clock cycle (busy is always low) and each result
// appears on done, in the order of the starts, for one cycle only; the receiver
// cannot stall it. The pipeline is two chains of 24 CORDIC cells (vectoring, then
// a pair of rotations run side by side) plus nine stages of scaling and duty math.
// mode_select and pwm_period must only be written while no transaction is in flight.
module foc_voltage_modulator_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int VOLT_BITS  = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  signed [VOLT_BITS-1:0] volt_q,
	input  wire  signed [VOLT_BITS-1:0] volt_d,
	input  wire  [ANGLE_BITS-1:0]       elec_angle,
	output logic                        done,
	output logic [15:0]                 compare_a,
	output logic [15:0]                 compare_b,
	output logic [15:0]                 compare_c,
	output logic [2:0]                  sector_num,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int VOLT_SH = fvm_pkg::FRAC + 2 - VOLT_BITS;
	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_PERIOD = 1'b1;
	localparam int STEPS = fvm_pkg::STEPS;

	// Configuration registers
	logic        mode_q;
	logic [15:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			period_q <= 16'd1000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_PERIOD: period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_PERIOD: prdata = {16'd0, period_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Stage 1: scale inputs and fold the vectoring input into the right half plane.
	fvm_pkg::val_t  vq_in;
	fvm_pkg::val_t  vd_in;
	fvm_pkg::turn_t ph_in;

	logic               valid_s1;
	fvm_pkg::vec_lane_t vlane_s1;
	fvm_pkg::vec_pass_t vpass_s1;

	always_comb begin
		vq_in = fvm_pkg::val_t'(volt_q) <<< VOLT_SH;
		vd_in = fvm_pkg::val_t'(volt_d) <<< VOLT_SH;
		ph_in = {elec_angle, {(32-ANGLE_BITS){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		vpass_s1.mode <= mode_q;
		vpass_s1.vq   <= vq_in;
		vpass_s1.vd   <= vd_in;
		vpass_s1.ph   <= ph_in;
		if (vd_in[fvm_pkg::VAL_W-1]) begin
			vlane_s1.x <= -vd_in;
			vlane_s1.y <= -vq_in;
			vlane_s1.z <= fvm_pkg::TURN_HALF;
		end else begin
			vlane_s1.x <= vd_in;
			vlane_s1.y <= vq_in;
			vlane_s1.z <= '0;
		end
	end

	// Vectoring chain: magnitude and atan2 of (Ud, Uq).
	logic               vvalid [0:STEPS];
	fvm_pkg::vec_lane_t vlane  [0:STEPS];
	fvm_pkg::vec_pass_t vpass  [0:STEPS];

	assign vvalid[0] = valid_s1;
	assign vlane[0]  = vlane_s1;
	assign vpass[0]  = vpass_s1;

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		fvm_vec_cell #(.STEP(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vvalid[i]),
			.in_lane  (vlane[i]),
			.in_pass  (vpass[i]),
			.out_valid(vvalid[i+1]),
			.out_lane (vlane[i+1]),
			.out_pass (vpass[i+1])
		);
	end

	// Stage 2: remove the CORDIC gain from the magnitude.
	logic               valid_s2;
	fvm_pkg::val_t      mag_s2;
	fvm_pkg::turn_t     atan_s2;
	fvm_pkg::vec_pass_t vpass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= vvalid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		mag_s2   <= fvm_pkg::mul_q(vlane[STEPS].x, fvm_pkg::INV_GAIN);
		atan_s2  <= vlane[STEPS].z;
		vpass_s2 <= vpass[STEPS];
	end

	// Stage 3: reference angle and sqrt(3) scaled magnitude.
	logic               valid_s3;
	fvm_pkg::val_t      ut_s3;
	fvm_pkg::turn_t     ph_s3;
	fvm_pkg::vec_pass_t vpass_s3;
	fvm_pkg::val_t      uout;
	fvm_pkg::turn_t     ph_ref;

	always_comb begin
		if (vpass_s2.vd != '0) begin
			uout   = mag_s2;
			ph_ref = vpass_s2.ph + atan_s2;
		end else begin
			uout   = vpass_s2.vq;
			ph_ref = vpass_s2.ph + fvm_pkg::TURN_QUARTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ut_s3    <= fvm_pkg::mul_q(uout, fvm_pkg::SQRT3_Q);
		ph_s3    <= vpass_s2.mode ? ph_ref : vpass_s2.ph;
		vpass_s3 <= vpass_s2;
	end

	// Stage 4: sector and the two in-sector angles, then rotation setup.
	logic               valid_s4;
	fvm_pkg::rot_lane_t ra_s4;
	fvm_pkg::rot_lane_t rb_s4;
	fvm_pkg::rot_pass_t rpass_s4;
	logic [34:0]        p6;
	logic [2:0]         sec;
	fvm_pkg::turn_t     ang_lo;
	fvm_pkg::turn_t     ang_hi;
	logic [33:0]        hi_full;

	always_comb begin
		p6      = ({3'd0, ph_s3} << 2) + ({3'd0, ph_s3} << 1);
		sec     = p6[34:32];
		ang_lo  = ph_s3 - fvm_pkg::sector_lo(sec);
		hi_full = fvm_pkg::sector_hi(sec) - {2'd0, ph_s3};
		ang_hi  = hi_full[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vpass_s3.mode) begin
			ra_s4           <= fvm_pkg::rot_init(ut_s3, '0, ang_lo);
			rpass_s4.sector <= sec + 3'd1;
		end else begin
			ra_s4           <= fvm_pkg::rot_init(vpass_s3.vd, vpass_s3.vq, ph_s3);
			rpass_s4.sector <= 3'd0;
		end
		rb_s4         <= fvm_pkg::rot_init(ut_s3, '0, ang_hi);
		rpass_s4.mode <= vpass_s3.mode;
	end

	// Rotation chain: lane A does inverse Park or T2, lane B does T1.
	logic               rvalid [0:STEPS];
	fvm_pkg::rot_lane_t ra     [0:STEPS];
	fvm_pkg::rot_lane_t rb     [0:STEPS];
	fvm_pkg::rot_pass_t rpass  [0:STEPS];

	assign rvalid[0] = valid_s4;
	assign ra[0]     = ra_s4;
	assign rb[0]     = rb_s4;
	assign rpass[0]  = rpass_s4;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		fvm_rot_cell #(.STEP(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (rvalid[i]),
			.in_a     (ra[i]),
			.in_b     (rb[i]),
			.in_pass  (rpass[i]),
			.out_valid(rvalid[i+1]),
			.out_a    (ra[i+1]),
			.out_b    (rb[i+1]),
			.out_pass (rpass[i+1])
		);
	end

	// Stage 5: gain removal.
	logic               valid_s5;
	fvm_pkg::val_t      xa_s5;
	fvm_pkg::val_t      ya_s5;
	fvm_pkg::val_t      yb_s5;
	fvm_pkg::rot_pass_t rpass_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= rvalid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		xa_s5    <= fvm_pkg::mul_q(ra[STEPS].x, fvm_pkg::INV_GAIN);
		ya_s5    <= fvm_pkg::mul_q(ra[STEPS].y, fvm_pkg::INV_GAIN);
		yb_s5    <= fvm_pkg::mul_q(rb[STEPS].y, fvm_pkg::INV_GAIN);
		rpass_s5 <= rpass[STEPS];
	end

	// Stage 6: phase duty fractions.
	logic          valid_s6;
	fvm_pkg::val_t ta_s6;
	fvm_pkg::val_t tb_s6;
	fvm_pkg::val_t tc_s6;
	logic [2:0]    sector_s6;
	fvm_pkg::val_t h;
	fvm_pkg::val_t b;
	fvm_pkg::val_t t12;
	fvm_pkg::val_t ta;
	fvm_pkg::val_t tb;
	fvm_pkg::val_t tc;

	always_comb begin
		t12 = ya_s5 + yb_s5;
		b   = fvm_pkg::mul_q(ya_s5, fvm_pkg::SQRT3_HALF);
		if (!rpass_s5.mode) begin
			h  = xa_s5 >>> 1;
			ta = xa_s5 + fvm_pkg::HALF_Q;
			tb = fvm_pkg::HALF_Q - h + b;
			tc = fvm_pkg::HALF_Q - h - b;
		end else begin
			// Lane A holds T2 and lane B holds T1; h is half of T0.
			h = (fvm_pkg::ONE_Q - t12) >>> 1;
			unique case (rpass_s5.sector)
				3'd1: begin ta = t12 + h;   tb = ya_s5 + h; tc = h;       end
				3'd2: begin ta = yb_s5 + h; tb = t12 + h;   tc = h;       end
				3'd3: begin ta = h;         tb = t12 + h;   tc = ya_s5 + h; end
				3'd4: begin ta = h;         tb = yb_s5 + h; tc = t12 + h; end
				3'd5: begin ta = ya_s5 + h; tb = h;         tc = t12 + h; end
				default: begin ta = t12 + h; tb = h;        tc = yb_s5 + h; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		ta_s6     <= ta;
		tb_s6     <= tb;
		tc_s6     <= tc;
		sector_s6 <= rpass_s5.sector;
	end

	// Stages 7 to 9: percent, period scaling and compare value per phase.
	fvm_duty u_duty_a (.clk(clk), .duty(ta_s6), .period(period_q), .compare(compare_a));
	fvm_duty u_duty_b (.clk(clk), .duty(tb_s6), .period(period_q), .compare(compare_b));
	fvm_duty u_duty_c (.clk(clk), .duty(tc_s6), .period(period_q), .compare(compare_c));

	logic       valid_s7;
	logic       valid_s8;
	logic       valid_s9;
	logic [2:0] sector_s7;
	logic [2:0] sector_s8;
	logic [2:0] sector_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		sector_s7 <= sector_s6;
		sector_s8 <= sector_s7;
		sector_s9 <= sector_s8;
	end

	assign done       = valid_s9;
	assign sector_num = sector_s9;

`ifndef SYNTHESIS
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sector_num <= 3'd6))
		else $error("sector number out of range");

	a_sector_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid[STEPS] |-> (rpass[STEPS].mode || rpass[STEPS].sector == 3'd0))
		else $error("sector set on a sinusoidal transaction");

	a_sector_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && rpass_s5.mode |-> (rpass_s5.sector != 3'd0))
		else $error("space vector transaction without a sector");
`endif

endmodule
`default_nettype wire

/* test/foc_voltage_modulator_unit_tb.sv */
`timescale 1ns / 1ps
module foc_voltage_modulator_unit_tb;

	localparam logic       MODE_SINE   = 1'b0;
	localparam logic       MODE_SVM    = 1'b1;
	localparam logic [2:0] ADDR_MODE   = 3'd0;
	localparam logic [2:0] ADDR_PERIOD = 3'd4;
	localparam int         LATENCY     = 57;
	localparam int         STALL_LIMIT = 5000;

	localparam longint ONE_FX      = 64'sd16777216;
	localparam longint HALF_FX     = 64'sd8388608;
	localparam longint GAIN_COMP   = 64'sd10188014;
	localparam longint ROOT3       = 64'sd29058991;
	localparam longint ROOT3_HALF  = 64'sd14529495;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [31:0] ARCTAN [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct {
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
		logic [15:0] cmp_c;
		logic [2:0]  sector;
	} pwm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] volt_q = '0;
	logic signed [15:0] volt_d = '0;
	logic [15:0] elec_angle = '0;
	logic done;
	logic [15:0] compare_a, compare_b, compare_c;
	logic [2:0] sector_num;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic        cfg_mode = MODE_SINE;
	logic [15:0] cfg_period = 16'd1000;

	pwm_result_t expected_pwm[$];
	int error_count = 0;
	int stall_cycles = 0;

	foc_voltage_modulator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.volt_q(volt_q), .volt_d(volt_d), .elec_angle(elec_angle),
		.done(done), .compare_a(compare_a), .compare_b(compare_b),
		.compare_c(compare_c), .sector_num(sector_num),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Rotates (x, y) by the turn angle and removes the CORDIC gain.
	function automatic void cordic_rotate(inout longint x, inout longint y,
			input logic [31:0] ph);
		longint z;
		longint dx;
		longint dy;
		logic [31:0] t;
		t = ph + QUARTER_TURN;
		if (t[31]) begin
			x = -x;
			y = -y;
			ph = ph + HALF_TURN;
		end
		z = ph[31] ? longint'({32'b0, ph}) - 64'sh1_0000_0000 : longint'({32'b0, ph});
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'({32'b0, ARCTAN[i]});
			end else begin
				x += dx; y -= dy; z += longint'({32'b0, ARCTAN[i]});
			end
		end
		x = (x * GAIN_COMP) >>> 24;
		y = (y * GAIN_COMP) >>> 24;
	endfunction

	function automatic logic [31:0] cordic_vector(output longint mag, input longint x,
			input longint y);
		logic [31:0] z;
		longint dx;
		longint dy;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z = z + ARCTAN[i];
			end else begin
				x -= dx; y += dy; z = z - ARCTAN[i];
			end
		end
		mag = (x * GAIN_COMP) >>> 24;
		return z;
	endfunction

	function automatic logic [15:0] duty_compare(input longint t);
		longint pct;
		longint c;
		pct = (t * 100) >>> 24;
		if (pct < 0) pct = 0;
		if (pct > 100) pct = 100;
		c = longint'({48'b0, cfg_period}) * pct / 100 - 1;
		if (c < 0) c = 0;
		return c[15:0];
	endfunction

	function automatic pwm_result_t predict_pwm(input logic signed [15:0] uq,
			input logic signed [15:0] ud, input logic [15:0] ang);
		longint vq, vd, ta, tb, tc, x, y, h, b, mag, ut, t1, t2;
		logic [31:0] ph;
		logic [63:0] p6, r;
		logic [31:0] s;
		pwm_result_t res;
		vq = longint'(uq) * 1024;
		vd = longint'(ud) * 1024;
		ph = {ang, 16'b0};
		res.sector = '0;
		if (cfg_mode == MODE_SINE) begin
			x = vd;
			y = vq;
			cordic_rotate(x, y, ph);
			h = x >>> 1;
			b = (y * ROOT3_HALF) >>> 24;
			ta = x + HALF_FX;
			tb = HALF_FX - h + b;
			tc = HALF_FX - h - b;
		end else begin
			if (vd != 0) begin
				ph = ph + cordic_vector(mag, vd, vq);
			end else begin
				mag = vq;
				ph = ph + QUARTER_TURN;
			end
			p6 = {32'b0, ph} * 64'd6;
			s = p6[63:32];
			r = {32'b0, p6[31:0]};
			ut = (mag * ROOT3) >>> 24;
			x = ut; y = 0;
			cordic_rotate(x, y, 32'(r / 64'd6));
			t2 = y;
			x = ut; y = 0;
			cordic_rotate(x, y, 32'((64'h1_0000_0000 - r) / 64'd6));
			t1 = y;
			h = (ONE_FX - t1 - t2) >>> 1;
			res.sector = 3'(s + 1);
			case (s)
				0: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
				1: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
				2: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
				3: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
				4: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
				default: begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
			endcase
		end
		res.cmp_a = duty_compare(ta);
		res.cmp_b = duty_compare(tb);
		res.cmp_c = duty_compare(tc);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		pwm_result_t want;
		if (arst_n && done) begin
			if (expected_pwm.size() == 0) begin
				// A result arrived with no transaction outstanding.
				report_mismatch("done", 1, 0);
			end else begin
				want = expected_pwm.pop_front();
				if (compare_a !== want.cmp_a) report_mismatch("compare_a", compare_a, want.cmp_a);
				if (compare_b !== want.cmp_b) report_mismatch("compare_b", compare_b, want.cmp_b);
				if (compare_c !== want.cmp_c) report_mismatch("compare_c", compare_c, want.cmp_c);
				if (sector_num !== want.sector)
					report_mismatch("sector_num", sector_num, want.sector);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic send_vector(input logic signed [15:0] uq, input logic signed [15:0] ud,
			input logic [15:0] ang);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		volt_q <= uq;
		volt_d <= ud;
		elec_angle <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_pwm.push_back(predict_pwm(uq, ud, ang));
	endtask

	// Lets every outstanding transaction finish before the registers change.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (expected_pwm.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MODE) cfg_mode = value[0];
		else if (addr == ADDR_PERIOD) cfg_period = value[15:0];
	endtask

	task automatic configure(input logic mode, input logic [15:0] period);
		drain();
		write_reg(ADDR_MODE, {31'b0, mode});
		write_reg(ADDR_PERIOD, {16'b0, period});
	endtask

	task automatic test_directed_sine;
		send_vector(16'sd0, 16'sd0, 16'd0);
		send_vector(16'sd32767, 16'sd0, 16'd0);
		send_vector(-16'sd32768, 16'sd0, 16'd16384);
		send_vector(16'sd8192, 16'sd8192, 16'd32768);
		send_vector(16'sd0, 16'sd32767, 16'd49152);
		send_vector(16'sd0, -16'sd32768, 16'd65535);
		send_vector(16'sd32767, 16'sd32767, 16'd12345);
	endtask

	task automatic test_directed_svm;
		// Zero direct voltage takes the quadrature voltage as magnitude, even negative.
		send_vector(16'sd8192, 16'sd0, 16'd0);
		send_vector(-16'sd8192, 16'sd0, 16'd10000);
		send_vector(16'sd0, 16'sd0, 16'd32768);
		send_vector(16'sd32767, 16'sd32767, 16'd65535);
		send_vector(-16'sd32768, -16'sd32768, 16'd0);
		send_vector(16'sd4000, -16'sd3000, 16'd16384);
		send_vector(-16'sd4000, 16'sd3000, 16'd49152);
		for (int s = 0; s < 6; s++)
			send_vector(16'sd6000, 16'sd0, 16'(s * 10923 + 100));
	endtask

	task automatic test_random(input int count);
		logic signed [15:0] uq, ud;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: begin uq = 16'($urandom); ud = 16'($urandom); end
				1: begin uq = 16'($urandom); ud = '0; end
				default: begin
					uq = 16'($signed(16'($urandom_range(0, 16384))) - 16'sd8192);
					ud = 16'($signed(16'($urandom_range(0, 16384))) - 16'sd8192);
				end
			endcase
			send_vector(uq, ud, 16'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sine();
		configure(MODE_SVM, 16'd1000);
		test_directed_svm();
		configure(MODE_SINE, 16'd1);
		test_random(250);
		configure(MODE_SVM, 16'd65535);
		test_random(250);
		configure(MODE_SINE, 16'd65535);
		test_random(250);
		configure(MODE_SVM, 16'd1);
		test_random(250);
		configure(MODE_SVM, 16'd100);
		test_random(250);
		configure(MODE_SINE, 16'($urandom_range(1, 65535)));
		test_random(250);
		configure(MODE_SVM, 16'($urandom_range(1, 65535)));
		test_random(250);
		drain();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* foc_voltage_modulator_unit.f */
hw/rtl/fvm_pkg.sv
hw/rtl/fvm_vec_cell.sv
hw/rtl/fvm_rot_cell.sv
hw/rtl/fvm_duty.sv
hw/rtl/foc_voltage_modulator_unit.sv
test/foc_voltage_modulator_unit_tb.sv
